@@ hdl/ltrie_pkg.sv @@
// Shared operation codes and controller state encoding for the letter trie.
package ltrie_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_PREFIX = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_MARK   = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_CLEAR  = 5'b10000
    } state_t;

endpackage

@@ hdl/ltrie_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one registered read port.
module ltrie_ram #(
    parameter int  DEPTH = 1024,
    parameter int  WIDTH = 10,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/letter_trie_insert_lookup_core.sv @@
// Letter trie core: insert, exact search, prefix query and clear over a node store in RAM.
// A letter's child RAM read is issued on transfer; ST_LOOKUP then follows the link or,
// for an insert, writes a new one, and a final search letter also reads its end mark in ST_MARK.
// A result that finds the output occupied waits in ST_EMIT. A new letter is taken only in ST_IDLE.
// Clear walks the child RAM one entry a cycle, NODES*ALPHABET entries (26624 by default).
// After reset the same clearing pass runs, with no input taken, before the first transfer.
module letter_trie_insert_lookup_core #(
    parameter int NODES    = 1024,
    parameter int ALPHABET = 26
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [4:0] letter,
    input  logic       last_letter,
    input  logic       empty_word,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       answer,
    output logic       status
);

    import ltrie_pkg::*;

    // Node identifiers, the bump allocator (which must be able to hold NODES itself)
    // and the flat child slot address, node * ALPHABET + letter.
    localparam int NW    = $clog2(NODES);
    localparam int FW    = $clog2(NODES + 1);
    localparam int SLOTS = NODES * ALPHABET;
    localparam int SW    = $clog2(SLOTS);

    // Controller state. The walk state (cursor and the two per-word flags) lives in
    // registers; the trie itself lives in the two RAMs below.
    state_t         state_reg, state_next;
    logic [SW-1:0]  sweep_reg, sweep_next;
    logic           clr_report_reg, clr_report_next;
    logic [NW-1:0]  cursor_reg, cursor_next;
    logic           missing_reg, missing_next;
    logic           overflow_reg, overflow_next;
    logic [FW-1:0]  next_free_reg, next_free_next;
    logic           out_valid_reg, out_valid_next;

    // Item payload held across the lookup.
    op_t            op_reg, op_next;
    logic           last_reg, last_next;
    logic           oor_reg, oor_next;
    logic [SW-1:0]  slot_reg, slot_next;

    // Result registers and the parked result used when the output is still occupied.
    logic           answer_reg, answer_next;
    logic           status_reg, status_next;
    logic           pend_answer_reg, pend_answer_next;
    logic           pend_status_reg, pend_status_next;

    // RAM ports.
    logic           child_we;
    logic [SW-1:0]  child_waddr;
    logic [NW-1:0]  child_wdata;
    logic           child_re;
    logic [SW-1:0]  child_raddr;
    logic [NW-1:0]  child_rdata;
    logic           mark_we;
    logic [NW-1:0]  mark_waddr;
    logic           mark_wdata;
    logic           mark_re;
    logic [NW-1:0]  mark_raddr;
    logic           mark_rdata;

    logic           accept;
    logic           letter_oor;
    logic [SW-1:0]  slot_calc;
    logic           out_free;
    logic           fin;
    logic           fin_answer;
    logic           fin_status;
    logic [NW-1:0]  walk_cursor;

    ltrie_ram #(
        .DEPTH (SLOTS),
        .WIDTH (NW)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (child_re),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    ltrie_ram #(
        .DEPTH (NODES),
        .WIDTH (1)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (mark_re),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // A letter beyond the alphabet has no child slot; the RAM is then read at slot zero
    // and the data is ignored.
    assign letter_oor = (32'(letter) >= ALPHABET);
    assign slot_calc  = letter_oor ? '0
                      : SW'(32'(cursor_reg) * 32'(ALPHABET) + 32'(letter));

    always_comb
    begin
        state_next       = state_reg;
        sweep_next       = sweep_reg;
        clr_report_next  = clr_report_reg;
        cursor_next      = cursor_reg;
        missing_next     = missing_reg;
        overflow_next    = overflow_reg;
        next_free_next   = next_free_reg;
        op_next          = op_reg;
        last_next        = last_reg;
        oor_next         = oor_reg;
        slot_next        = slot_reg;
        answer_next      = answer_reg;
        status_next      = status_reg;
        pend_answer_next = pend_answer_reg;
        pend_status_next = pend_status_reg;
        out_valid_next   = out_valid_reg && !out_ready;

        child_we    = 1'b0;
        child_waddr = slot_reg;
        child_wdata = next_free_reg[NW-1:0];
        child_re    = 1'b0;
        child_raddr = slot_calc;
        mark_we     = 1'b0;
        mark_waddr  = '0;
        mark_wdata  = 1'b1;
        mark_re     = 1'b0;
        mark_raddr  = '0;

        fin         = 1'b0;
        fin_answer  = 1'b0;
        fin_status  = 1'b0;
        walk_cursor = cursor_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = op_t'(opcode);
                    last_next = last_letter;
                    oor_next  = letter_oor;
                    slot_next = slot_calc;
                    if (op_t'(opcode) == OP_CLEAR)
                    begin
                        // Clear outranks every other field and abandons any word in progress.
                        clr_report_next = 1'b1;
                        sweep_next      = '0;
                        state_next      = ST_CLEAR;
                    end
                    else if (empty_word)
                    begin
                        // The zero-length word acts on the root alone.
                        cursor_next   = '0;
                        missing_next  = 1'b0;
                        overflow_next = 1'b0;
                        case (op_t'(opcode))
                            OP_INSERT:
                            begin
                                mark_we    = 1'b1;
                                fin        = 1'b1;
                                fin_answer = 1'b1;
                            end
                            OP_SEARCH:
                            begin
                                mark_re    = 1'b1;
                                state_next = ST_MARK;
                            end
                            default:
                            begin
                                fin        = 1'b1;
                                fin_answer = 1'b1;
                            end
                        endcase
                    end
                    else
                    begin
                        child_re   = 1'b1;
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                // Child data for the transferred letter is on the RAM output now.
                if (op_reg == OP_INSERT)
                begin
                    if (!overflow_reg)
                    begin
                        if (oor_reg)
                        begin
                            overflow_next = 1'b1;
                        end
                        else if (child_rdata == '0)
                        begin
                            if (next_free_reg == FW'(NODES))
                            begin
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                // Allocate the next fresh node and link it in place.
                                child_we       = 1'b1;
                                walk_cursor    = next_free_reg[NW-1:0];
                                next_free_next = next_free_reg + FW'(1);
                            end
                        end
                        else
                        begin
                            walk_cursor = child_rdata;
                        end
                    end
                end
                else
                begin
                    if (!missing_reg)
                    begin
                        if (oor_reg || child_rdata == '0)
                        begin
                            missing_next = 1'b1;
                        end
                        else
                        begin
                            walk_cursor = child_rdata;
                        end
                    end
                end
                cursor_next = walk_cursor;
                state_next  = ST_IDLE;

                if (last_reg)
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            // A word that ran out of nodes is left unmarked.
                            mark_we    = !overflow_next;
                            mark_waddr = walk_cursor;
                            fin        = 1'b1;
                            fin_answer = 1'b1;
                            fin_status = overflow_next;
                        end
                        OP_SEARCH:
                        begin
                            mark_re    = 1'b1;
                            mark_raddr = walk_cursor;
                            state_next = ST_MARK;
                        end
                        default:
                        begin
                            fin        = 1'b1;
                            fin_answer = !missing_next;
                        end
                    endcase
                    if (op_reg != OP_SEARCH)
                    begin
                        cursor_next   = '0;
                        missing_next  = 1'b0;
                        overflow_next = 1'b0;
                    end
                end
            end

            ST_MARK:
            begin
                fin           = 1'b1;
                fin_answer    = !missing_reg && mark_rdata;
                cursor_next   = '0;
                missing_next  = 1'b0;
                overflow_next = 1'b0;
            end

            ST_EMIT:
            begin
                fin        = 1'b1;
                fin_answer = pend_answer_reg;
                fin_status = pend_status_reg;
            end

            ST_CLEAR:
            begin
                // One child entry a cycle; the end marks share the first NODES addresses.
                child_we    = 1'b1;
                child_waddr = sweep_reg;
                child_wdata = '0;
                mark_we     = (sweep_reg < SW'(NODES));
                mark_waddr  = sweep_reg[NW-1:0];
                mark_wdata  = 1'b0;
                sweep_next  = sweep_reg + SW'(1);
                if (sweep_reg == SW'(SLOTS - 1))
                begin
                    sweep_next      = '0;
                    next_free_next  = FW'(1);
                    cursor_next     = '0;
                    missing_next    = 1'b0;
                    overflow_next   = 1'b0;
                    clr_report_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (clr_report_reg)
                    begin
                        fin        = 1'b1;
                        fin_answer = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free,
        // otherwise it is parked until the downstream transfer frees the slot.
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next = 1'b1;
                answer_next    = fin_answer;
                status_next    = fin_status;
                state_next     = ST_IDLE;
            end
            else
            begin
                pend_answer_next = fin_answer;
                pend_status_next = fin_status;
                state_next       = ST_EMIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            sweep_reg      <= '0;
            clr_report_reg <= 1'b0;
            cursor_reg     <= '0;
            missing_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            next_free_reg  <= FW'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            sweep_reg      <= sweep_next;
            clr_report_reg <= clr_report_next;
            cursor_reg     <= cursor_next;
            missing_reg    <= missing_next;
            overflow_reg   <= overflow_next;
            next_free_reg  <= next_free_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        last_reg        <= last_next;
        oor_reg         <= oor_next;
        slot_reg        <= slot_next;
        answer_reg      <= answer_next;
        status_reg      <= status_next;
        pend_answer_reg <= pend_answer_next;
        pend_status_reg <= pend_status_next;
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

`ifndef NO_ASSERTIONS
    // The bump allocator never runs past the store and never hands out the root.
    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg >= FW'(1) && next_free_reg <= FW'(NODES))
        else $error("next free node out of range");

    // Outside a clearing pass the cursor only ever points at an allocated node.
    a_cursor_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_CLEAR |-> {1'b0, cursor_reg} < {1'b0, next_free_reg})
        else $error("cursor points at an unallocated node");

    // A clear transfer always starts the sweep.
    a_clear_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_CLEAR |=> state_reg == ST_CLEAR)
        else $error("clear did not start the sweep");

    // Every child link written during a lookup consumes exactly one fresh node.
    a_alloc_step: assert property (@(posedge clk) disable iff (!rst_n)
        child_we && state_reg == ST_LOOKUP |=> next_free_reg == $past(next_free_reg) + FW'(1))
        else $error("node allocation did not advance the allocator");
`endif

endmodule
